@@ design/gpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared constants for the green pixel centroid block: field widths,
// configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package gpc_pkg;

	localparam int CHAN_W      = 8;   // red, green, blue
	localparam int TOL_W       = 8;   // tolerance register
	localparam int IMG_W_W     = 13;  // image_width register
	localparam int CFG_DATA_W  = 13;  // widest register
	localparam int CFG_INDEX_W = 1;
	localparam int CENT_W      = 12;  // centroid_x, centroid_y
	localparam int GCOUNT_W    = 25;  // green_count

	localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE   = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 1'b1;

	localparam logic [TOL_W-1:0]   TOLERANCE_RESET   = 8'd50;
	localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET = 13'd640;

endpackage
`default_nettype wire

@@ design/gpc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gpc_front
// Accepts pixels, classifies them as green, tracks column and row, and
// accumulates the count and coordinate sums of green pixels. At the end of a
// frame it pushes the totals into the frame queue and clears itself.
// ----------------------------------------------------------------------------
module gpc_front #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int CNT_W      = 25,
	parameter int SUM_W      = 37
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	// configuration
	input  wire                                     cfg_write,
	input  wire  [gpc_pkg::CFG_INDEX_W-1:0]         cfg_index,
	input  wire  [gpc_pkg::CFG_DATA_W-1:0]          cfg_data,
	// pixel channel
	input  wire                                     in_valid,
	output logic                                    in_stall,
	input  wire  [gpc_pkg::CHAN_W-1:0]              red,
	input  wire  [gpc_pkg::CHAN_W-1:0]              green,
	input  wire  [gpc_pkg::CHAN_W-1:0]              blue,
	input  wire                                     last_of_frame,
	// frame queue
	input  wire                                     q_full,
	output logic                                    q_push,
	output logic [CNT_W-1:0]                        push_count,
	output logic [SUM_W-1:0]                        push_sum_x,
	output logic [SUM_W-1:0]                        push_sum_y
);

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CAP    = MAX_WIDTH * MAX_HEIGHT;
	localparam int LIM_RAW = $clog2(MAX_WIDTH + 1);
	localparam int LIM_W  = (LIM_RAW > gpc_pkg::IMG_W_W) ? LIM_RAW : gpc_pkg::IMG_W_W;

	logic [gpc_pkg::TOL_W-1:0]   tolerance_q;
	logic [gpc_pkg::IMG_W_W-1:0] image_width_q;
	logic [COL_W-1:0]            column_q;
	logic [ROW_W-1:0]            row_q;
	logic [CNT_W-1:0]            count_q;
	logic [SUM_W-1:0]            sum_x_q;
	logic [SUM_W-1:0]            sum_y_q;

	logic                        accept;
	logic                        is_green;
	logic                        take;
	logic [gpc_pkg::CHAN_W:0]    red_lim;
	logic [gpc_pkg::CHAN_W:0]    blue_lim;
	logic [LIM_W-1:0]            width_ext;
	logic [LIM_W-1:0]            limit;
	logic [LIM_W-1:0]            col_inc;
	logic                        wrap;
	logic [ROW_W:0]              row_inc;
	logic [CNT_W-1:0]            count_n;
	logic [SUM_W-1:0]            sum_x_n;
	logic [SUM_W-1:0]            sum_y_n;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	assign red_lim  = {1'b0, red} + {1'b0, tolerance_q};
	assign blue_lim = {1'b0, blue} + {1'b0, tolerance_q};
	assign is_green = ({1'b0, green} > red_lim) && ({1'b0, green} > blue_lim);
	// Green pixels past the cap are ignored so the sums cannot overflow.
	assign take     = is_green && (count_q < CNT_W'(CAP));

	assign count_n = count_q + CNT_W'(take);
	assign sum_x_n = take ? sum_x_q + SUM_W'(column_q) : sum_x_q;
	assign sum_y_n = take ? sum_y_q + SUM_W'(row_q) : sum_y_q;

	// A width of zero counts as one pixel per row; wider rows wrap at the maximum.
	assign width_ext = LIM_W'(image_width_q);
	always_comb begin
		priority if (image_width_q == '0) begin
			limit = LIM_W'(1);
		end else if (width_ext > LIM_W'(MAX_WIDTH)) begin
			limit = LIM_W'(MAX_WIDTH);
		end else begin
			limit = width_ext;
		end
	end
	assign col_inc = LIM_W'(column_q) + LIM_W'(1);
	assign wrap    = col_inc >= limit;
	assign row_inc = {1'b0, row_q} + (ROW_W+1)'(1);

	assign q_push     = accept && last_of_frame;
	assign push_count = count_n;
	assign push_sum_x = sum_x_n;
	assign push_sum_y = sum_y_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q   <= gpc_pkg::TOLERANCE_RESET;
			image_width_q <= gpc_pkg::IMAGE_WIDTH_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				gpc_pkg::REG_TOLERANCE:   tolerance_q   <= cfg_data[gpc_pkg::TOL_W-1:0];
				gpc_pkg::REG_IMAGE_WIDTH: image_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			count_q  <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
		end else if (accept) begin
			if (last_of_frame) begin
				column_q <= '0;
				row_q    <= '0;
				count_q  <= '0;
				sum_x_q  <= '0;
				sum_y_q  <= '0;
			end else begin
				count_q <= count_n;
				sum_x_q <= sum_x_n;
				sum_y_q <= sum_y_n;
				if (wrap) begin
					column_q <= '0;
					if (row_inc < (ROW_W+1)'(MAX_HEIGHT)) begin
						row_q <= row_inc[ROW_W-1:0];
					end
				end else begin
					column_q <= col_inc[COL_W-1:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ design/gpc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gpc_queue
// Two-entry queue of frame totals between the pixel front end and the
// divider back end.
// ----------------------------------------------------------------------------
module gpc_queue #(
	parameter int WIDTH = 97
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] push_data,
	input  wire              pop,
	output logic [WIDTH-1:0] head_data,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [0:1];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	assign full      = fill_q == 2'd2;
	assign empty     = fill_q == 2'd0;
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("frame queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("frame queue read while empty");
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n) fill_q != 2'd3)
		else $error("frame queue fill level out of range");

endmodule
`default_nettype wire

@@ design/gpc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// gpc_back
// Takes one frame's totals from the queue, divides both coordinate sums by
// the count one quotient bit per cycle, and holds the result until taken.
// ----------------------------------------------------------------------------
module gpc_back #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	parameter int CNT_W      = 25,
	parameter int SUM_W      = 37
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// frame queue
	input  wire                                q_empty,
	output logic                               q_pop,
	input  wire  [CNT_W-1:0]                   head_count,
	input  wire  [SUM_W-1:0]                   head_sum_x,
	input  wire  [SUM_W-1:0]                   head_sum_y,
	// result channel
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic                               found_green,
	output logic [gpc_pkg::CENT_W-1:0]         centroid_x,
	output logic [gpc_pkg::CENT_W-1:0]         centroid_y,
	output logic [gpc_pkg::GCOUNT_W-1:0]       green_count
);

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int ITER   = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int STEP_W = (ITER > 1) ? $clog2(ITER) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0]        state_q;
	logic [SUM_W-1:0]  rem_x_q;
	logic [SUM_W-1:0]  rem_y_q;
	logic [SUM_W-1:0]  dsh_q;
	logic [ITER-1:0]   quo_x_q;
	logic [ITER-1:0]   quo_y_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;

	logic              ge_x;
	logic              ge_y;
	logic              found;
	logic [31:0]       quo_x_w;
	logic [31:0]       quo_y_w;
	logic [31:0]       cnt_w;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;
	assign ge_x  = rem_x_q >= dsh_q;
	assign ge_y  = rem_y_q >= dsh_q;

	// The mean of a coordinate is below its maximum, so ITER quotient bits suffice.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_DIV;
						step_q  <= STEP_W'(ITER - 1);
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						state_q     <= ST_OUT;
						out_valid_q <= 1'b1;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_x_q <= head_sum_x;
			rem_y_q <= head_sum_y;
			dsh_q   <= SUM_W'(head_count) << (ITER - 1);
			cnt_q   <= head_count;
			quo_x_q <= '0;
			quo_y_q <= '0;
		end else if (state_q == ST_DIV) begin
			if (ge_x) begin
				rem_x_q <= rem_x_q - dsh_q;
			end
			if (ge_y) begin
				rem_y_q <= rem_y_q - dsh_q;
			end
			quo_x_q <= (quo_x_q << 1) | ITER'(ge_x);
			quo_y_q <= (quo_y_q << 1) | ITER'(ge_y);
			dsh_q   <= dsh_q >> 1;
		end
	end

	assign found   = cnt_q != '0;
	assign quo_x_w = 32'(quo_x_q);
	assign quo_y_w = 32'(quo_y_q);
	assign cnt_w   = 32'(cnt_q);

	assign out_valid   = out_valid_q;
	assign found_green = found;
	assign centroid_x  = found ? quo_x_w[gpc_pkg::CENT_W-1:0] : '0;
	assign centroid_y  = found ? quo_y_w[gpc_pkg::CENT_W-1:0] : '0;
	assign green_count = cnt_w[gpc_pkg::GCOUNT_W-1:0];

	a_empty_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found_green) |->
		(centroid_x == '0 && centroid_y == '0 && green_count == '0))
		else $error("empty frame reported a nonzero result");
	a_pop_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_DIV && !out_valid_q))
		else $error("division did not start after taking a frame");
	a_div_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (!out_valid_q && !q_pop))
		else $error("result shown or queue read during division");

endmodule
`default_nettype wire

@@ design/green_pixel_centroid.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// green_pixel_centroid
// Finds the count and truncated centroid of green pixels in a raster-order
// RGB frame and reports them once per frame.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// pixel     in         in_valid/in_stall   red, green, blue, last_of_frame
// result    out        out_valid/out_stall found_green, centroid_x, centroid_y,
//                                          green_count
// config    in         cfg_write           cfg_index, cfg_data
//
// Pixels are accepted one per cycle while in_stall is low. Each frame's
// totals wait in a two-entry queue; the back end divides one quotient bit
// per cycle after its frame leaves the queue. in_stall rises only while the
// queue is full. Reset restores tolerance 50 and width 640 and clears all
// counters.
// ----------------------------------------------------------------------------
module green_pixel_centroid #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_write,
	input  wire  [gpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire  [gpc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire  [gpc_pkg::CHAN_W-1:0]        red,
	input  wire  [gpc_pkg::CHAN_W-1:0]        green,
	input  wire  [gpc_pkg::CHAN_W-1:0]        blue,
	input  wire                               last_of_frame,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic                              found_green,
	output logic [gpc_pkg::CENT_W-1:0]        centroid_x,
	output logic [gpc_pkg::CENT_W-1:0]        centroid_y,
	output logic [gpc_pkg::GCOUNT_W-1:0]      green_count
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int ITER  = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CAP   = MAX_WIDTH * MAX_HEIGHT;
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int SUM_W = CNT_W + ITER;
	localparam int Q_W   = CNT_W + 2 * SUM_W;

	logic             q_full;
	logic             q_empty;
	logic             q_push;
	logic             q_pop;
	logic [CNT_W-1:0] push_count;
	logic [SUM_W-1:0] push_sum_x;
	logic [SUM_W-1:0] push_sum_y;
	logic [Q_W-1:0]   head_data;

	gpc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.last_of_frame (last_of_frame),
		.q_full        (q_full),
		.q_push        (q_push),
		.push_count    (push_count),
		.push_sum_x    (push_sum_x),
		.push_sum_y    (push_sum_y)
	);

	gpc_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({push_count, push_sum_x, push_sum_y}),
		.pop       (q_pop),
		.head_data (head_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	gpc_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CNT_W      (CNT_W),
		.SUM_W      (SUM_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.head_count  (head_data[Q_W-1 -: CNT_W]),
		.head_sum_x  (head_data[2*SUM_W-1 -: SUM_W]),
		.head_sum_y  (head_data[SUM_W-1:0]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found_green (found_green),
		.centroid_x  (centroid_x),
		.centroid_y  (centroid_y),
		.green_count (green_count)
	);

endmodule
`default_nettype wire
